// ===== hdl/tet_pkg.sv =====
// Shared types and codes for the topology entry table.
// No dependencies; imported by tet_store and topology_entry_table.
`default_nettype none

package tet_pkg;

  localparam logic [1:0] ACT_ADD    = 2'd0;
  localparam logic [1:0] ACT_REMOVE = 2'd1;
  localparam logic [1:0] ACT_CHECK  = 2'd2;
  localparam logic [1:0] ACT_GET    = 2'd3;

  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_NO_MATCH = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;

  localparam logic [15:0] SEQ_NONE = 16'hFFFF;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] origin_rtr;
    logic [31:0] subnet;
    logic [31:0] prefix_mask;
    logic [31:0] peer_rtr;
    logic [31:0] gateway;
    logic [15:0] seq_num;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] sequence_out;
    logic [6:0]  entry_total;
  } rsp_t;

  typedef struct packed {
    logic [31:0] rid;
    logic [31:0] subnet;
    logic [31:0] mask;
    logic [31:0] neighbor;
    logic [31:0] hop;
    logic [15:0] seq;
  } entry_t;

endpackage

`default_nettype wire

// ===== hdl/tet_store.sv =====
// Entry memory: one write port, one read port, registered read data.
// Depends on tet_pkg for the entry type.
`default_nettype none

module tet_store
  import tet_pkg::*;
#(
  parameter int DEPTH = 64,
  parameter int IW    = 6
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [IW-1:0] wr_addr,
  input  wire entry_t        wr_data,
  input  wire logic          rd_en,
  input  wire logic [IW-1:0] rd_addr,
  output entry_t             rd_data
);

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/topology_entry_table.sv =====
// Topology entry table: entries kept in insertion order in one memory, searched
// oldest first through its single read port, one entry per cycle. An add passes
// through the done state, which registers its result once the output register is
// free. Check, get and remove walk the n stored entries, ending early on a match;
// a remove that hits entry m then moves entries m+1..n-1 down one slot per cycle.
// One item is in work at a time; a finished result waits in the output register.
// Reset is immediate: no clearing pass.
// Depends on tet_pkg and tet_store.
`default_nettype none

module topology_entry_table
  import tet_pkg::*;
#(
  parameter int TABLE_DEPTH = 64
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_ready,
  input  wire req_t req,
  output logic      rsp_valid,
  input  wire logic rsp_ready,
  output rsp_t      rsp
);

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_SHIFT = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]    state;
  logic [CW-1:0] count;
  req_t          cur;
  logic [CW-1:0] ptr;
  logic          cmp_vld;
  logic [CW-1:0] cmp_idx;
  logic [1:0]    res_status;
  logic [15:0]   res_seq;

  logic          wr_en;
  logic [IW-1:0] wr_addr;
  entry_t        wr_data;
  logic          rd_en;
  entry_t        rd_data;
  logic          hit;
  logic [CW+6:0] cnt_ext;

  tet_store #(
    .DEPTH (TABLE_DEPTH),
    .IW    (IW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (ptr[IW-1:0]),
    .rd_data (rd_data)
  );

  assign req_ready = (state == S_IDLE);
  assign cnt_ext   = {7'd0, count};

  always_comb begin
    unique case (cur.action)
      ACT_REMOVE: hit = (rd_data.subnet == cur.subnet) && (rd_data.hop == cur.gateway);
      ACT_CHECK:  hit = (rd_data.rid == cur.origin_rtr) && (rd_data.subnet == cur.subnet);
      ACT_GET:    hit = (rd_data.rid == cur.origin_rtr) && (rd_data.hop == cur.gateway);
      default:    hit = 1'b0;
    endcase
  end

  always_comb begin
    rd_en   = 1'b0;
    wr_en   = 1'b0;
    wr_addr = count[IW-1:0];
    wr_data = '{rid: req.origin_rtr, subnet: req.subnet, mask: req.prefix_mask,
                neighbor: req.peer_rtr, hop: req.gateway, seq: req.seq_num};
    unique case (state)
      S_IDLE: begin
        wr_en = req_valid && (req.action == ACT_ADD) && (count != DEPTH_C);
      end
      S_SCAN: begin
        rd_en = (ptr < count) && !(cmp_vld && hit);
      end
      S_SHIFT: begin
        rd_en   = (ptr < count);
        wr_en   = cmp_vld;
        wr_addr = cmp_idx[IW-1:0];
        wr_data = rd_data;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      cmp_vld   <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready && (state != S_DONE)) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            cur     <= req;
            ptr     <= '0;
            cmp_vld <= 1'b0;
            if (req.action == ACT_ADD) begin
              res_seq <= '0;
              if (count == DEPTH_C) begin
                res_status <= ST_FULL;
              end else begin
                res_status <= ST_DONE;
                count      <= count + 1'b1;
              end
              state <= S_DONE;
            end else begin
              res_status <= ST_NO_MATCH;
              res_seq    <= (req.action == ACT_GET) ? SEQ_NONE : 16'd0;
              state      <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (cmp_vld && hit) begin
            res_status <= ST_DONE;
            cmp_vld    <= 1'b0;
            if (cur.action == ACT_GET) begin
              res_seq <= rd_data.seq;
            end
            if (cur.action == ACT_REMOVE) begin
              ptr   <= cmp_idx + 1'b1;
              state <= S_SHIFT;
            end else begin
              state <= S_DONE;
            end
          end else if (rd_en) begin
            ptr     <= ptr + 1'b1;
            cmp_vld <= 1'b1;
            cmp_idx <= ptr;
          end else begin
            cmp_vld <= 1'b0;
            if (!cmp_vld) begin
              state <= S_DONE;
            end
          end
        end
        S_SHIFT: begin
          if (rd_en) begin
            ptr     <= ptr + 1'b1;
            cmp_vld <= 1'b1;
            cmp_idx <= ptr - 1'b1;
          end else begin
            cmp_vld <= 1'b0;
            if (!cmp_vld) begin
              count <= count - 1'b1;
              state <= S_DONE;
            end
          end
        end
        S_DONE: begin
          if (!rsp_valid || rsp_ready) begin
            rsp_valid <= 1'b1;
            rsp       <= '{status: res_status, sequence_out: res_seq,
                           entry_total: cnt_ext[6:0]};
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // count stays within the table
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= DEPTH_C)
    else $error("entry count beyond table depth");

  // writes land inside the occupied region or at the append slot
  a_wr_range: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> ({1'b0, wr_addr} < {1'b0, count} + 1'b1))
    else $error("write past the append slot");

  // compare stage only ever looks at held entries
  a_cmp_range: assert property (@(posedge clk) disable iff (rst)
    (cmp_vld && state == S_SCAN) |-> (cmp_idx < count))
    else $error("compare of an entry beyond the count");

  // count moves by at most one per item
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |=> (count == $past(count)) ||
                          (count == $past(count) - 1'b1))
    else $error("count changed unexpectedly during a search");

  // a result is only issued from the completion state
  a_rsp_src: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> ($past(state) == S_DONE))
    else $error("result issued outside completion");

endmodule

`default_nettype wire
